// File: rtl/core/sliding_window_maximum_defines.svh
// Assertion macros used by the sliding window maximum RTL.
`ifndef SLIDING_WINDOW_MAXIMUM_DEFINES_SVH
`define SLIDING_WINDOW_MAXIMUM_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SWM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: rtl/core/swm_pkg.sv
// Shared types and constants of the sliding window maximum block.
package swm_pkg;

  // Width of a stream position; positions wrap at this width.
  localparam int unsigned PosW = 16;

  // Width of the window size register.
  localparam int unsigned CfgW = 7;

  // Register byte addresses on the configuration port.
  localparam logic [2:0] RegWindowSizeAddr = 3'd0;

  // Per-cycle command broadcast to every queue cell.
  typedef struct packed {
    logic load;   // take a new sample this cycle
    logic shift;  // drop the front candidate, cells pull from the right
  } cell_ctrl_t;

endpackage

// File: rtl/core/swm_cell.sv
// One candidate slot of the monotonic queue; trades entries with its right neighbor.
module swm_cell #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  swm_pkg::cell_ctrl_t           ctrl_i,
  input  logic [SAMPLE_BITS-1:0]        x_i,
  input  logic [swm_pkg::PosW-1:0]      p_i,
  input  logic                          nxt_valid_i,
  input  logic [SAMPLE_BITS-1:0]        nxt_val_i,
  input  logic [swm_pkg::PosW-1:0]      nxt_pos_i,
  input  logic                          kept_i,
  input  logic                          prev_kept_i,
  output logic                          valid_o,
  output logic [SAMPLE_BITS-1:0]        val_o,
  output logic [swm_pkg::PosW-1:0]      pos_o,
  output logic                          gt_o
);

  logic                     valid_q, valid_d;
  logic [SAMPLE_BITS-1:0]   val_q, val_d;
  logic [swm_pkg::PosW-1:0] pos_q, pos_d;
  logic                     src_valid;
  logic [SAMPLE_BITS-1:0]   src_val;
  logic [swm_pkg::PosW-1:0] src_pos;

  // Entry that lands here after an optional front drop
  always_comb begin
    src_valid = ctrl_i.shift ? nxt_valid_i : valid_q;
    src_val   = ctrl_i.shift ? nxt_val_i   : val_q;
    src_pos   = ctrl_i.shift ? nxt_pos_i   : pos_q;
  end

  // Load: keep the landing entry if larger than the sample, else take the sample
  // in the first freed slot, else go empty. Shift alone: pull from the right.
  always_comb begin
    valid_d = valid_q;
    val_d   = val_q;
    pos_d   = pos_q;
    if (ctrl_i.load) begin
      if (kept_i) begin
        valid_d = src_valid;
        val_d   = src_val;
        pos_d   = src_pos;
      end else if (prev_kept_i) begin
        valid_d = 1'b1;
        val_d   = x_i;
        pos_d   = p_i;
      end else begin
        valid_d = 1'b0;
      end
    end else if (ctrl_i.shift) begin
      valid_d = src_valid;
      val_d   = src_val;
      pos_d   = src_pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    pos_q <= pos_d;
  end

  // Stored candidate beats the incoming sample
  assign gt_o    = valid_q && ($signed(val_q) > $signed(x_i));
  assign valid_o = valid_q;
  assign val_o   = val_q;
  assign pos_o   = pos_q;

endmodule

// File: rtl/core/swm_out_buf.sv
// Two-entry output buffer: output register plus skid slot.
module swm_out_buf #(
  parameter int unsigned DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              space_o,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o,
  input  logic              ready_i
);

  logic              main_valid_q, main_valid_d;
  logic              skid_valid_q, skid_valid_d;
  logic [DATA_W-1:0] main_q, main_d;
  logic [DATA_W-1:0] skid_q, skid_d;
  logic              advance;

  // Output slot frees when empty or drained this cycle
  assign advance = !main_valid_q || ready_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (advance) begin
      if (skid_valid_q) begin
        main_valid_d = 1'b1;
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = push_i;
        main_d       = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign space_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

endmodule

// File: rtl/core/sliding_window_maximum.sv
// Top level: sliding window maximum over a sample stream with a cell-chain monotonic queue.
//
//   channel   direction  handshake                 payload
//   s_axis    in         s_axis_tvalid/tready      tdata: sample; tuser: start_of_sequence
//   m_axis    out        m_axis_tvalid/tready      tdata: window_max, window_start
//   apb       in         psel/penable/pwrite       paddr 0: window_size
//
// One sample per cycle while s_axis_tready is high: every queue cell compares
// against the new sample in parallel and takes its next entry from itself, its
// right neighbor or the sample bus, so the queue update and the result are computed in the same cycle.
// After a window size decrease the queue trims one stale front entry per
// cycle, with s_axis_tready low. A result is registered in the output
// register, or in the skid slot while m_axis stalls, before it shows on
// m_axis; the skid slot lets input flow on during an output stall until it fills.
// Reset empties the queue and sets window_size to 1.
`include "sliding_window_maximum_defines.svh"

module sliding_window_maximum #(
  parameter int unsigned WINDOW_MAX  = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // sample stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [SAMPLE_BITS-1:0] sample, zero fill above
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // [0] start_of_sequence
  input  logic                                 s_axis_tuser,
  // result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [SAMPLE_BITS-1:0] window_max, [SAMPLE_BITS+15:SAMPLE_BITS] window_start,
  // zero fill above
  output logic [((SAMPLE_BITS+23)/8)*8-1:0]    m_axis_tdata,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int unsigned WinW  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned PosW  = swm_pkg::PosW;
  localparam int unsigned CfgW  = swm_pkg::CfgW;
  localparam int unsigned ResW  = SAMPLE_BITS + PosW;
  localparam int unsigned OutW  = ((SAMPLE_BITS + 23) / 8) * 8;

  // Configuration register
  logic [CfgW-1:0] win_cfg_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == swm_pkg::RegWindowSizeAddr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cfg_q <= CfgW'(1);
    end else if (cfg_wr) begin
      win_cfg_q <= pwdata[CfgW-1:0];
    end
  end

  assign prdata = (paddr == swm_pkg::RegWindowSizeAddr) ? 32'(win_cfg_q) : 32'd0;

  // Clamp the window size to 1..WINDOW_MAX
  logic [WinW-1:0] win_eff;

  always_comb begin
    if (win_cfg_q == '0) begin
      win_eff = WinW'(1);
    end else if (32'(win_cfg_q) > 32'(WINDOW_MAX)) begin
      win_eff = WinW'(WINDOW_MAX);
    end else begin
      win_eff = WinW'(win_cfg_q);
    end
  end

  // Stream state
  logic [PosW-1:0] pos_q, pos_d;
  logic [WinW-1:0] fill_q, fill_d;

  logic [SAMPLE_BITS-1:0] x;
  logic                   start;
  logic                   accept;
  logic                   trim;
  logic                   expire;
  logic                   out_space;
  logic [PosW-1:0]        p_cur;
  swm_pkg::cell_ctrl_t    ctrl;

  // Cell entries, with an always-empty slot past the last cell
  logic [WINDOW_MAX:0]    ent_valid;
  logic [SAMPLE_BITS-1:0] ent_val [WINDOW_MAX+1];
  logic [PosW-1:0]        ent_pos [WINDOW_MAX+1];
  logic [WINDOW_MAX:0]    ent_gt;
  logic [WINDOW_MAX-1:0]  kept;
  logic [WINDOW_MAX-1:0]  prev_kept;

  assign x     = s_axis_tdata[SAMPLE_BITS-1:0];
  assign start = s_axis_tuser;
  assign p_cur = start ? '0 : pos_q;

  // Drop stale entries beyond the front one while idle
  assign trim = ent_valid[1] && ((pos_q - ent_pos[1]) >= PosW'(win_eff));

  // Front entry leaves the window with this sample
  assign expire = !start && ent_valid[0] && ((pos_q - ent_pos[0]) >= PosW'(win_eff));

  assign s_axis_tready = out_space && !trim;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign ctrl.load  = accept;
  assign ctrl.shift = accept ? expire : trim;

  assign ent_valid[WINDOW_MAX] = 1'b0;
  assign ent_val[WINDOW_MAX]   = '0;
  assign ent_pos[WINDOW_MAX]   = '0;
  assign ent_gt[WINDOW_MAX]    = 1'b0;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    // Keep decision for the entry that lands in slot i
    assign kept[i] = !start && (ctrl.shift ? ent_gt[i+1] : ent_gt[i]);
    if (i == 0) begin : g_head
      assign prev_kept[i] = 1'b1;
    end else begin : g_body
      assign prev_kept[i] = kept[i-1];
    end

    swm_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .x_i         (x),
      .p_i         (p_cur),
      .nxt_valid_i (ent_valid[i+1]),
      .nxt_val_i   (ent_val[i+1]),
      .nxt_pos_i   (ent_pos[i+1]),
      .kept_i      (kept[i]),
      .prev_kept_i (prev_kept[i]),
      .valid_o     (ent_valid[i]),
      .val_o       (ent_val[i]),
      .pos_o       (ent_pos[i]),
      .gt_o        (ent_gt[i])
    );
  end

  // Advance position and fill count per sample
  always_comb begin
    pos_d  = pos_q;
    fill_d = fill_q;
    if (accept) begin
      pos_d = p_cur + PosW'(1);
      if (start) begin
        fill_d = WinW'(1);
      end else if (32'(fill_q) < 32'(WINDOW_MAX)) begin
        fill_d = fill_q + WinW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      fill_q <= '0;
    end else begin
      pos_q  <= pos_d;
      fill_q <= fill_d;
    end
  end

  // Result: new front of the queue and the window's first position
  logic [SAMPLE_BITS-1:0] res_max;
  logic [PosW-1:0]        res_start;
  logic                   res_push;
  logic [ResW-1:0]        res_data;
  logic [ResW-1:0]        out_data;

  assign res_max   = kept[0] ? (ctrl.shift ? ent_val[1] : ent_val[0]) : x;
  assign res_start = p_cur - PosW'(win_eff) + PosW'(1);
  assign res_push  = accept && (fill_d >= win_eff);
  assign res_data  = {res_start, res_max};

  swm_out_buf #(
    .DATA_W(ResW)
  ) u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res_data),
    .space_o     (out_space),
    .valid_o     (m_axis_tvalid),
    .data_o      (out_data),
    .ready_i     (m_axis_tready)
  );

  assign m_axis_tdata = OutW'(out_data);

  // The second queue value lies strictly below the front one
  `SWM_ASSERT(a_front_order, ent_valid[1] |-> (ent_valid[0] && ($signed(ent_val[0]) > $signed(ent_val[1]))), "queue order broken at front")
  // Every accepted sample leaves a front candidate
  `SWM_ASSERT(a_front_after_accept, accept |=> ent_valid[0], "queue empty after a sample")
  // A sequence start leaves only the new sample in the queue
  `SWM_ASSERT(a_start_clears, (accept && start) |=> !ent_valid[1], "start did not clear the queue")
  // No sample is taken while stale entries remain past the front
  `SWM_ASSERT_ALWAYS(a_no_accept_in_trim, !(trim && accept), "sample taken during trim")

endmodule
